FILE: rtl/core/siph_pkg.sv
// ---------------------------------------------------------------------------
// siph_pkg
// Shared types, constants and helpers for the SipHash streaming core.
// ---------------------------------------------------------------------------
package siph_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned VB_W        = 4;
    localparam int unsigned LEN_W       = 8;
    localparam int unsigned RND_W       = 4;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned MAX_ROUNDS  = 15;

    localparam logic [WORD_W-1:0] SEED_A = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SEED_B = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SEED_C = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SEED_D = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FIN_XOR = 64'h00000000000000ff;

    localparam logic [RND_W-1:0] RND_RESET_C = 4'd1;
    localparam logic [RND_W-1:0] RND_RESET_D = 4'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C_ROUNDS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_D_ROUNDS = 3'd3;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } lanes_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_FINAL
    } state_t;

    // Round count clipped to the supported maximum.
    function automatic logic [RND_W-1:0] cap_rounds(input logic [RND_W-1:0] n);
        logic [RND_W-1:0] r;
        if (32'(n) > MAX_ROUNDS)
            r = RND_W'(MAX_ROUNDS);
        else
            r = n;
        return r;
    endfunction

    // Keep the low vb bytes of a word (vb in 1..7).
    function automatic logic [WORD_W-1:0] byte_mask(input logic [VB_W-1:0] vb);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (32'(vb) > i)
                m[i*8 +: 8] = 8'hff;
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/siph_round.sv
// ---------------------------------------------------------------------------
// siph_round
// One SipRound over the four lanes; the shared mixing unit of the core.
// ---------------------------------------------------------------------------
module siph_round
    import siph_pkg::*;
(
    input  lanes_t lanes_in,
    output lanes_t lanes_out
);

    logic [WORD_W-1:0] a0, a1, a2, a3;
    logic [WORD_W-1:0] b0, b1, b2, b3;

    always_comb
    begin
        // first half
        a0 = lanes_in.v0 + lanes_in.v1;
        a1 = {lanes_in.v1[50:0], lanes_in.v1[63:51]} ^ a0;
        a0 = {a0[31:0], a0[63:32]};
        a2 = lanes_in.v2 + lanes_in.v3;
        a3 = {lanes_in.v3[47:0], lanes_in.v3[63:48]} ^ a2;
        // second half
        b0 = a0 + a3;
        b3 = {a3[42:0], a3[63:43]} ^ b0;
        b2 = a2 + a1;
        b1 = {a1[46:0], a1[63:47]} ^ b2;
        b2 = {b2[31:0], b2[63:32]};

        lanes_out.v0 = b0;
        lanes_out.v1 = b1;
        lanes_out.v2 = b2;
        lanes_out.v3 = b3;
    end

endmodule

FILE: rtl/core/siphash_streaming_core.sv
// ---------------------------------------------------------------------------
// siphash_streaming_core
// Keyed SipHash-c-d over a message streamed as little-endian 64-bit words.
// ---------------------------------------------------------------------------
// One SipRound unit is reused for every round under a small sequencer. With c
// compression and d finalization rounds, a non-last word takes c rounds, a
// partial or empty last word c then d, a full last word c, c more for a
// length-only block, then d; in_stall is high unless the sequencer is idle.
// The hash goes to an output register, so the next word is taken while a
// result waits on out_stall. The key is sampled when a message starts.
module siphash_streaming_core
    import siph_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_W-1:0]    data_word,
    input  logic [VB_W-1:0]      valid_bytes,
    input  logic                 last,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_W-1:0]    hash_value
);

    // configuration
    logic [WORD_W-1:0] key_low_reg, key_high_reg;
    logic [RND_W-1:0]  c_rounds_reg, d_rounds_reg;

    // sequencer and datapath
    state_t            state_reg, state_next;
    lanes_t            lanes_reg, lanes_next;
    lanes_t            lanes_mixed;
    logic [WORD_W-1:0] blk_reg, blk_next;
    logic [WORD_W-1:0] blk2_reg, blk2_next;
    logic              pend2_reg, pend2_next;
    logic              last_reg, last_next;
    logic [RND_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              fresh_reg, fresh_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] hash_reg, hash_next;

    logic              in_take;
    logic              out_free;
    logic              fin_done;
    lanes_t            base;
    logic [LEN_W-1:0]  base_len;
    logic [LEN_W-1:0]  len8;
    logic [VB_W-1:0]   vb_sat;

    siph_round u_round (
        .lanes_in  (lanes_reg),
        .lanes_out (lanes_mixed)
    );

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign fin_done = (state_reg == ST_FINAL) && (cnt_reg == '0) && out_free;
    assign in_take  = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_ABSORB;
            end
            ST_ABSORB:
            begin
                if (cnt_reg == '0 && !pend2_reg)
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL:
            begin
                if (fin_done)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            default: in_stall = 1'b1;
        endcase
    end

    // datapath
    always_comb
    begin
        lanes_next     = lanes_reg;
        blk_next       = blk_reg;
        blk2_next      = blk2_reg;
        pend2_next     = pend2_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && out_stall;
        hash_next      = hash_reg;

        if (fresh_reg)
        begin
            base.v0  = SEED_A ^ key_low_reg;
            base.v1  = SEED_B ^ key_high_reg;
            base.v2  = SEED_C ^ key_low_reg;
            base.v3  = SEED_D ^ key_high_reg;
            base_len = '0;
        end
        else
        begin
            base     = lanes_reg;
            base_len = len_reg;
        end
        len8   = base_len + LEN_W'(8);
        vb_sat = valid_bytes[3] ? VB_W'(8) : valid_bytes;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    fresh_next = 1'b0;
                    last_next  = last;
                    pend2_next = 1'b0;
                    cnt_next   = cap_rounds(c_rounds_reg);
                    blk2_next  = {len8, 56'd0};
                    if (!last)
                    begin
                        blk_next = data_word;
                        len_next = len8;
                    end
                    else if (vb_sat == VB_W'(8))
                    begin
                        // full last word, then a length-only block
                        blk_next   = data_word;
                        len_next   = len8;
                        pend2_next = 1'b1;
                    end
                    else if (vb_sat == '0)
                    begin
                        blk_next = {base_len, 56'd0};
                        len_next = base_len;
                    end
                    else
                    begin
                        len_next = base_len + LEN_W'(vb_sat);
                        blk_next = (data_word & byte_mask(vb_sat))
                                 | {base_len + LEN_W'(vb_sat), 56'd0};
                    end
                    lanes_next    = base;
                    lanes_next.v3 = base.v3 ^ blk_next;
                end
            end
            ST_ABSORB:
            begin
                if (cnt_reg != '0)
                begin
                    lanes_next = lanes_mixed;
                    cnt_next   = cnt_reg - RND_W'(1);
                end
                else
                begin
                    lanes_next.v0 = lanes_reg.v0 ^ blk_reg;
                    if (pend2_reg)
                    begin
                        pend2_next    = 1'b0;
                        blk_next      = blk2_reg;
                        lanes_next.v3 = lanes_reg.v3 ^ blk2_reg;
                        cnt_next      = cap_rounds(c_rounds_reg);
                    end
                    else if (last_reg)
                    begin
                        lanes_next.v2 = lanes_reg.v2 ^ FIN_XOR;
                        cnt_next      = cap_rounds(d_rounds_reg);
                    end
                end
            end
            ST_FINAL:
            begin
                if (cnt_reg != '0)
                begin
                    lanes_next = lanes_mixed;
                    cnt_next   = cnt_reg - RND_W'(1);
                end
                else if (out_free)
                begin
                    hash_next      = lanes_reg.v0 ^ lanes_reg.v1
                                   ^ lanes_reg.v2 ^ lanes_reg.v3;
                    out_valid_next = 1'b1;
                    fresh_next     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            c_rounds_reg  <= RND_RESET_C;
            d_rounds_reg  <= RND_RESET_D;
            state_reg     <= ST_IDLE;
            lanes_reg     <= '0;
            pend2_reg     <= 1'b0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    REG_C_ROUNDS: c_rounds_reg <= cfg_data[RND_W-1:0];
                    REG_D_ROUNDS: d_rounds_reg <= cfg_data[RND_W-1:0];
                    default: ;
                endcase
            end
            state_reg     <= state_next;
            lanes_reg     <= lanes_next;
            pend2_reg     <= pend2_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        blk2_reg <= blk2_next;
        hash_reg <= hash_next;
    end

endmodule
